// ----- rtl/core/umpq_pkg.sv -----
package umpq_pkg;

    // queue depth, index and count widths derived from it, and fixed data, priority and fill widths
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int FILL_W = 5;

    typedef logic [DATA_W-1:0]        t_data;
    typedef logic signed [PRIO_W-1:0] t_prio;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [FILL_W-1:0]        t_fill;

    typedef enum logic {
        FUNC_INSERT  = 1'b0,
        FUNC_EXTRACT = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    // one table entry as stored in the RAM
    typedef struct packed {
        t_data data;
        t_prio prio;
    } t_entry;

    // RAM write port
    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry entry;
    } t_ram_wr;

endpackage

// ----- rtl/core/unsorted_max_priority_queue_unit.sv -----
// Channel   Direction  Transfer when           Signals
// command   in         start && !busy          i_func, i_item_data, i_priority_req
// result    out        o_done (one cycle)      o_out_data, o_out_priority, o_status, o_fill
//
// Insert, full-queue insert and empty extract: result in the cycle after the transfer,
// busy stays low, so a new command may follow every cycle.
// Extract on a non-empty queue: a scan reads every held entry to find the winner, then
// a close-up moves each entry behind the winner down one place; busy stays high until
// the result, as every read goes through the single registered RAM read port.
// Reset (i_rst_n low, synchronous) empties the queue; RAM is not cleared. No output stall.
module unsorted_max_priority_queue_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_func,
    input  umpq_pkg::t_data       i_item_data,
    input  umpq_pkg::t_prio       i_priority_req,
    output logic                  o_done,
    output umpq_pkg::t_data       o_out_data,
    output umpq_pkg::t_prio       o_out_priority,
    output logic [1:0]            o_status,
    output umpq_pkg::t_fill       o_fill
);

    // control state
    umpq_pkg::t_state  r_state,    n_state;
    umpq_pkg::t_cnt    r_cnt,      n_cnt;      // entries held
    umpq_pkg::t_cnt    r_rd_idx,   n_rd_idx;   // next RAM read index
    logic              r_rd_vld,   n_rd_vld;   // RAM data valid this cycle
    umpq_pkg::t_idx    r_rd_tag,   n_rd_tag;   // index of that RAM data
    logic              r_done,     n_done;

    // running maximum of the scan
    umpq_pkg::t_idx    r_best_idx, n_best_idx;
    umpq_pkg::t_data   r_best_data, n_best_data;
    umpq_pkg::t_prio   r_best_prio, n_best_prio;

    // result payload
    umpq_pkg::t_data   r_out_data, n_out_data;
    umpq_pkg::t_prio   r_out_prio, n_out_prio;
    umpq_pkg::t_status r_status,   n_status;
    umpq_pkg::t_fill   r_fill,     n_fill;

    umpq_pkg::t_ram_wr ram_wr;
    umpq_pkg::t_idx    ram_rd_addr;
    umpq_pkg::t_entry  ram_rd;

    logic              issue;      // a read is launched this cycle
    logic              take;       // returned entry becomes the new maximum

    umpq_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd)
    );

    // low bits only; index DEPTH is never launched as a real read
    assign ram_rd_addr = r_rd_idx[umpq_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= umpq_pkg::S_IDLE;
            r_cnt    <= '0;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_idx <= n_rd_idx;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag    <= n_rd_tag;
        r_best_idx  <= n_best_idx;
        r_best_data <= n_best_data;
        r_best_prio <= n_best_prio;
        r_out_data  <= n_out_data;
        r_out_prio  <= n_out_prio;
        r_status    <= n_status;
        r_fill      <= n_fill;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd_idx    = r_rd_idx;
        n_rd_vld    = 1'b0;
        n_rd_tag    = r_rd_tag;
        n_done      = 1'b0;
        n_best_idx  = r_best_idx;
        n_best_data = r_best_data;
        n_best_prio = r_best_prio;
        n_out_data  = r_out_data;
        n_out_prio  = r_out_prio;
        n_status    = r_status;
        n_fill      = r_fill;
        ram_wr      = '0;

        issue = (r_state != umpq_pkg::S_IDLE) && (r_rd_idx != r_cnt);
        // first entry always taken; >= lets the newest entry win a tie
        take  = r_rd_vld && ((r_rd_tag == '0) || (ram_rd.prio >= r_best_prio));

        if (issue) begin
            n_rd_idx = r_rd_idx + 1'b1;
            n_rd_vld = 1'b1;
            n_rd_tag = r_rd_idx[umpq_pkg::IDX_W-1:0];
        end

        unique case (r_state)
            umpq_pkg::S_IDLE: begin
                if (start) begin
                    if (umpq_pkg::t_func'(i_func) == umpq_pkg::FUNC_INSERT) begin
                        n_done     = 1'b1;
                        n_out_data = '0;
                        n_out_prio = '0;
                        if (r_cnt == umpq_pkg::t_cnt'(umpq_pkg::DEPTH)) begin
                            n_status = umpq_pkg::ST_FULL;
                        end else begin
                            ram_wr.en          = 1'b1;
                            ram_wr.addr        = r_cnt[umpq_pkg::IDX_W-1:0];
                            ram_wr.entry.data  = i_item_data;
                            ram_wr.entry.prio  = i_priority_req;
                            n_cnt              = r_cnt + 1'b1;
                            n_status           = umpq_pkg::ST_OK;
                        end
                        n_fill = umpq_pkg::t_fill'(n_cnt);
                    end else if (r_cnt == '0) begin
                        n_done     = 1'b1;
                        n_out_data = '0;
                        n_out_prio = '0;
                        n_status   = umpq_pkg::ST_EMPTY;
                        n_fill     = '0;
                    end else begin
                        n_state  = umpq_pkg::S_SCAN;
                        n_rd_idx = '0;
                    end
                end
            end

            umpq_pkg::S_SCAN: begin
                if (take) begin
                    n_best_idx  = r_rd_tag;
                    n_best_data = ram_rd.data;
                    n_best_prio = ram_rd.prio;
                end
                if (r_rd_vld &&
                    (r_rd_tag == umpq_pkg::t_idx'(r_cnt - 1'b1))) begin
                    // last entry seen: close up the table behind the winner
                    n_state  = umpq_pkg::S_SHIFT;
                    n_rd_idx = umpq_pkg::t_cnt'(n_best_idx) + 1'b1;
                end
            end

            umpq_pkg::S_SHIFT: begin
                if (r_rd_vld) begin
                    ram_wr.en    = 1'b1;
                    ram_wr.addr  = r_rd_tag - 1'b1;
                    ram_wr.entry = ram_rd;
                end
                if (!issue && !r_rd_vld) begin
                    n_state    = umpq_pkg::S_IDLE;
                    n_cnt      = r_cnt - 1'b1;
                    n_done     = 1'b1;
                    n_out_data = r_best_data;
                    n_out_prio = r_best_prio;
                    n_status   = umpq_pkg::ST_OK;
                    n_fill     = umpq_pkg::t_fill'(n_cnt);
                end
            end

            default: begin
                n_state = umpq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != umpq_pkg::S_IDLE);
    assign o_done         = r_done;
    assign o_out_data     = r_out_data;
    assign o_out_priority = r_out_prio;
    assign o_status       = r_status;
    assign o_fill         = r_fill;

    // count stays within the table
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= umpq_pkg::t_cnt'(umpq_pkg::DEPTH))
        else $error("entry count above depth");

    // every accepted command either answers next cycle or starts a scan
    a_cmd_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_done || busy)
        else $error("command lost");

    // close-up never writes the entry being read
    a_shift_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == umpq_pkg::S_SHIFT) && ram_wr.en |-> ram_wr.addr != ram_rd_addr)
        else $error("close-up read/write overlap");

    // an extract only runs on a non-empty queue
    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_cnt != '0)
        else $error("scan with empty queue");

endmodule

// ----- rtl/core/umpq_ram.sv -----
module umpq_ram (
    input  logic               i_clk,
    input  umpq_pkg::t_ram_wr  i_wr,
    input  umpq_pkg::t_idx     i_rd_addr,
    output umpq_pkg::t_entry   o_rd_data
);

    umpq_pkg::t_entry mem [umpq_pkg::DEPTH];
    umpq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.entry;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- verif/tb.sv -----
module tb;

    // Drop the run after this many cycles without a transfer on either side.
    // The slowest item is an extract over a full queue; the sender also adds a random
    // gap before each command. The limit is far above both.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1250;
    // Settle time after the last result, from the worst-case extract latency.
    localparam int TAIL_CYCLES = 2 * umpq_pkg::DEPTH + 8;

    typedef struct {
        umpq_pkg::t_data data;
        umpq_pkg::t_prio prio;
        logic [1:0]      status;
        umpq_pkg::t_fill fill;
    } t_outcome;

    // Tracks the queue contents in age order, oldest first, and predicts the
    // outcome of every command transfer.
    class extract_order_checker;
        umpq_pkg::t_data held_data[$];
        umpq_pkg::t_prio held_prio[$];
        t_outcome        due_outcomes[$];
        int              mismatches;

        function int held_count();
            return held_data.size();
        endfunction

        function int outstanding();
            return due_outcomes.size();
        endfunction

        function void note_command(logic func, umpq_pkg::t_data data,
                                   umpq_pkg::t_prio prio);
            t_outcome o;
            int       best;
            o.data   = '0;
            o.prio   = '0;
            o.status = umpq_pkg::ST_OK;
            if (func == umpq_pkg::FUNC_INSERT) begin
                if (held_data.size() >= umpq_pkg::DEPTH) begin
                    o.status = umpq_pkg::ST_FULL;
                end else begin
                    held_data.push_back(data);
                    held_prio.push_back(prio);
                end
            end else if (held_data.size() == 0) begin
                o.status = umpq_pkg::ST_EMPTY;
            end else begin
                // Signed maximum; >= so the newest of equal priorities wins.
                best = 0;
                for (int i = 1; i < held_prio.size(); i++) begin
                    if (held_prio[i] >= held_prio[best]) begin
                        best = i;
                    end
                end
                o.data = held_data[best];
                o.prio = held_prio[best];
                held_data.delete(best);
                held_prio.delete(best);
            end
            o.fill = umpq_pkg::t_fill'(held_data.size());
            due_outcomes.push_back(o);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", what);
            end
        endfunction

        function void check_result(umpq_pkg::t_data data, umpq_pkg::t_prio prio,
                                   logic [1:0] status, umpq_pkg::t_fill fill);
            t_outcome o;
            if (due_outcomes.size() == 0) begin
                flag($sformatf("result with nothing due: data %h prio %0d status %0d fill %0d",
                               data, prio, status, fill));
                return;
            end
            o = due_outcomes.pop_front();
            if (o.data !== data || o.prio !== prio || o.status !== status || o.fill !== fill) begin
                flag($sformatf({"result mismatch: expected data %h prio %0d status %0d ",
                                "fill %0d, got data %h prio %0d status %0d fill %0d"},
                               o.data, o.prio, o.status, o.fill, data, prio, status, fill));
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic            i_func;
    umpq_pkg::t_data i_item_data;
    umpq_pkg::t_prio i_priority_req;
    logic            o_done;
    umpq_pkg::t_data o_out_data;
    umpq_pkg::t_prio o_out_priority;
    logic [1:0]      o_status;
    umpq_pkg::t_fill o_fill;

    extract_order_checker order_check = new();
    int idle_max;
    int quiet_cycles;

    unsorted_max_priority_queue_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_item_data    (i_item_data),
        .i_priority_req (i_priority_req),
        .o_done         (o_done),
        .o_out_data     (o_out_data),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_fill         (o_fill)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Both transfers are sampled at the edge, before any NBA update lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                order_check.note_command(i_func, i_item_data, i_priority_req);
            end
            if (o_done) begin
                order_check.check_result(o_out_data, o_out_priority, o_status, o_fill);
            end
            if ((start && !busy) || o_done) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("unsorted_max_priority_queue_unit test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Holds one command until its transfer. Start stays high into the next
    // command when no gap is drawn, so it is never dropped and raised in one step.
    task automatic send_command(umpq_pkg::t_func func, umpq_pkg::t_data data,
                                umpq_pkg::t_prio prio);
        int gap;
        gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= func;
        i_item_data    <= data;
        i_priority_req <= prio;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_queue_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (order_check.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic umpq_pkg::t_prio pick_priority();
        case ($urandom_range(0, 3))
            0: return umpq_pkg::t_prio'($urandom);
            // narrow band, so ties are common
            1: return umpq_pkg::t_prio'($signed($urandom_range(0, 6)) - 3);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: return umpq_pkg::t_prio'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    initial begin
        umpq_pkg::t_prio fill_prio [16];
        int              sent;
        int              phase_len;
        int              p_insert;
        umpq_pkg::t_func func;

        fill_prio = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sd5, 16'sd5,
                      16'sh7fff, 16'sh8000, 16'sd100, -16'sd100, 16'sd5, 16'sd1,
                      -16'sd2, 16'sh7fff, 16'sh0000, 16'sd7};
        quiet_cycles   <= 0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_func         <= umpq_pkg::FUNC_INSERT;
        i_item_data    <= '0;
        i_priority_req <= '0;
        idle_max = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty extract, lone entry, fill to the top with extreme
        // values and tied priorities, drop on full, then pull out the ties.
        send_command(umpq_pkg::FUNC_EXTRACT, 32'hffff_ffff, 16'sh7fff);
        send_command(umpq_pkg::FUNC_INSERT, 32'hffff_ffff, 16'sh8000);
        send_command(umpq_pkg::FUNC_EXTRACT, 32'h0, 16'sh0);
        idle_max = 18;
        for (int i = 0; i < umpq_pkg::DEPTH; i++) begin
            send_command(umpq_pkg::FUNC_INSERT,
                         (i % 2 == 0) ? 32'h0 + i : 32'hffff_fff0 | i,
                         fill_prio[i % 16]);
        end
        send_command(umpq_pkg::FUNC_INSERT, 32'h1234_5678, 16'sh7fff);
        repeat (4) send_command(umpq_pkg::FUNC_EXTRACT, 32'hffff_ffff, 16'sh8000);

        // Random: phases with their own insert bias walk the fill level
        // between empty and full; some phases run back to back.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 80);
            p_insert  = $urandom_range(15, 85);
            idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 18;
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                func = ($urandom_range(0, 99) < p_insert) ? umpq_pkg::FUNC_INSERT
                                                          : umpq_pkg::FUNC_EXTRACT;
                send_command(func, umpq_pkg::t_data'($urandom), pick_priority());
                sent++;
            end
            // now and then wait for every due result before the next phase
            if ($urandom_range(0, 4) == 0) begin
                drain_queue_results();
            end
        end

        drain_queue_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (order_check.mismatches == 0 && order_check.outstanding() == 0) begin
            $display("unsorted_max_priority_queue_unit test passed");
        end else begin
            $display("unsorted_max_priority_queue_unit test failed");
        end
        $finish;
    end
endmodule

// ----- unsorted_max_priority_queue_unit.f -----
rtl/core/umpq_pkg.sv
rtl/core/umpq_ram.sv
rtl/core/unsorted_max_priority_queue_unit.sv
verif/tb.sv
